FILE: rtl/lc3is_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lc3is_pkg
// Shared types, constants and helpers for the LC-3 instruction step core.
// ----------------------------------------------------------------------------
package lc3is_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam int RF_DEPTH  = 8;
    localparam int RF_AW     = 3;

    localparam logic [15:0] ADDR_MASK    = 16'((32'd1 << ADDR_BITS) - 32'd1);
    localparam logic [15:0] START_PC_RST = 16'h3000;
    localparam logic [15:0] HALT_WORD    = 16'hF025;
    localparam logic [15:0] SIGN_BIT     = 16'h8000;

    localparam logic [2:0] CC_N = 3'h4;
    localparam logic [2:0] CC_Z = 3'h2;
    localparam logic [2:0] CC_P = 3'h1;

    localparam logic [2:0] LINK_REG = 3'd7;

    // apb register map, word index taken from paddr[2]
    localparam int          CFG_ADDR_BITS = 3;
    localparam logic [0:0]  REG_START_PC  = 1'b0;

    typedef enum logic {
        ITEM_LOAD = 1'b0,
        ITEM_STEP = 1'b1
    } t_item_kind;

    typedef enum logic [3:0] {
        OP_BR   = 4'h0,
        OP_ADD  = 4'h1,
        OP_LD   = 4'h2,
        OP_ST   = 4'h3,
        OP_JSR  = 4'h4,
        OP_AND  = 4'h5,
        OP_LDR  = 4'h6,
        OP_STR  = 4'h7,
        OP_RTI  = 4'h8,
        OP_NOT  = 4'h9,
        OP_LDI  = 4'hA,
        OP_STI  = 4'hB,
        OP_JMP  = 4'hC,
        OP_RES  = 4'hD,
        OP_LEA  = 4'hE,
        OP_TRAP = 4'hF
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_RA,
        ST_RB,
        ST_IND
    } t_state;

    typedef struct packed {
        logic        opcode;
        logic [15:0] load_address;
        logic [15:0] load_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pc_after;
        logic [15:0] instr_word;
        logic [2:0]  cond_after;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_written;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
        logic        halted;
    } t_out_item;

    typedef struct packed {
        logic ready;
        logic clearing;
        logic done;
    } t_core_sts;

    function automatic logic [15:0] sext5(input logic [15:0] ir);
        return {{11{ir[4]}}, ir[4:0]};
    endfunction

    function automatic logic [15:0] sext6(input logic [15:0] ir);
        return {{10{ir[5]}}, ir[5:0]};
    endfunction

    function automatic logic [15:0] sext9(input logic [15:0] ir);
        return {{7{ir[8]}}, ir[8:0]};
    endfunction

    function automatic logic [15:0] sext11(input logic [15:0] ir);
        return {{5{ir[10]}}, ir[10:0]};
    endfunction

    function automatic logic [2:0] codes_of(input logic [15:0] v);
        logic [2:0] cc;
        if (v == 16'h0000) begin
            cc = CC_Z;
        end else if ((v & SIGN_BIT) != 16'h0000) begin
            cc = CC_N;
        end else begin
            cc = CC_P;
        end
        return cc;
    endfunction

    function automatic logic [15:0] mask_addr(input logic [15:0] a);
        return a & ADDR_MASK;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/lc3_instruction_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lc3_instruction_step
// LC-3 core with internal word memory, item channels and an apb port.
// ----------------------------------------------------------------------------
// a step walks the core states idle, dec, ra and rb (ldi adds ind), set by the
// single port of the word memory (fetch, data reads, write); a load or a halted
// step completes in idle; one input buffer and one output register sit on entry
// and exit; after reset all 2^ADDR_BITS words of memory are cleared, one a cycle,
// and while that runs no transfer is taken on the input channel
// ----------------------------------------------------------------------------
module lc3_instruction_step (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire lc3is_pkg::t_in_item                  i_in_data,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output lc3is_pkg::t_out_item                      o_out_data,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lc3is_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    logic [15:0]          r_start_pc;
    logic                 r_buf_vld;
    lc3is_pkg::t_in_item  r_buf;
    logic                 r_out_vld;
    lc3is_pkg::t_out_item r_out;

    logic                 cfg_wr, reg_sel;
    logic                 in_take, out_free, start;
    lc3is_pkg::t_core_sts sts;
    lc3is_pkg::t_out_item res;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[lc3is_pkg::CFG_ADDR_BITS-1:2] == lc3is_pkg::REG_START_PC);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {16'h0000, r_start_pc} : 32'h0000_0000;

    assign o_in_stall = r_buf_vld || sts.clearing;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign start      = r_buf_vld && sts.ready && out_free;

    lc3is_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (r_buf),
        .i_cfg_wr (cfg_wr),
        .i_cfg_pc (pwdata[15:0]),
        .o_sts    (sts),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc <= lc3is_pkg::START_PC_RST;
            r_buf_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_start_pc <= pwdata[15:0];
            end
            if (in_take) begin
                r_buf_vld <= 1'b1;
            end else if (start) begin
                r_buf_vld <= 1'b0;
            end
            if (sts.done) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_buf <= i_in_data;
        end
        if (sts.done) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: rtl/lc3is_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lc3is_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lc3is_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/lc3is_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lc3is_core
// Instruction sequencer around the word memory and the register file RAM.
// ----------------------------------------------------------------------------
module lc3is_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire lc3is_pkg::t_in_item   i_item,
    input  wire logic                  i_cfg_wr,
    input  wire logic [15:0]           i_cfg_pc,
    output lc3is_pkg::t_core_sts       o_sts,
    output lc3is_pkg::t_out_item       o_res
);

    localparam int AW = lc3is_pkg::ADDR_BITS;

    lc3is_pkg::t_state r_state, n_state;
    logic [15:0]       r_pc, n_pc;
    logic [2:0]        r_cc, n_cc;
    logic              r_halt, n_halt;
    logic [15:0]       r_ir, n_ir;
    logic [15:0]       r_a, n_a;
    logic [lc3is_pkg::RF_DEPTH-1:0] r_rf_vld;
    logic              r_rf_rd_vld;
    logic              r_clr_act;
    logic [AW-1:0]     r_clr_addr;

    logic              mem_en, mem_we;
    logic [AW-1:0]     mem_addr;
    logic [15:0]       mem_wdata, mem_rdata;
    logic              rf_en, rf_we;
    logic [lc3is_pkg::RF_AW-1:0] rf_addr;
    logic [15:0]       rf_wdata, rf_rdata, rf_rd;

    lc3is_pkg::t_op    op;
    logic [15:0]       pc_inc, off9, off6_ra, off6_rb, b_val;
    logic              done, rw, mw;
    logic [2:0]        ri;
    logic [15:0]       rv, ma, mv, instr;

    lc3is_ram #(
        .WIDTH (16),
        .DEPTH (lc3is_pkg::MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    lc3is_ram #(
        .WIDTH (16),
        .DEPTH (lc3is_pkg::RF_DEPTH)
    ) u_rf (
        .i_clk   (i_clk),
        .i_en    (rf_en),
        .i_we    (rf_we),
        .i_addr  (rf_addr),
        .i_wdata (rf_wdata),
        .o_rdata (rf_rdata)
    );

    // registers never written read as zero
    assign rf_rd   = r_rf_rd_vld ? rf_rdata : 16'h0000;
    assign op      = lc3is_pkg::t_op'(r_ir[15:12]);
    assign pc_inc  = r_pc + 16'd1;
    assign off9    = pc_inc + lc3is_pkg::sext9(r_ir);
    assign off6_ra = rf_rd + lc3is_pkg::sext6(r_ir);
    assign off6_rb = r_a + lc3is_pkg::sext6(r_ir);
    assign b_val   = r_ir[5] ? lc3is_pkg::sext5(r_ir) : rf_rd;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_cc      = r_cc;
        n_halt    = r_halt;
        n_ir      = r_ir;
        n_a       = r_a;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        rf_en     = 1'b0;
        rf_we     = 1'b0;
        rf_addr   = '0;
        rf_wdata  = '0;
        done      = 1'b0;
        rw        = 1'b0;
        mw        = 1'b0;
        ri        = '0;
        rv        = '0;
        ma        = '0;
        mv        = '0;
        instr     = '0;

        unique case (r_state)
            lc3is_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_item.opcode == lc3is_pkg::ITEM_LOAD) begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = i_item.load_address[AW-1:0];
                        mem_wdata = i_item.load_data;
                        done      = 1'b1;
                    end else if (r_halt) begin
                        done = 1'b1;
                    end else begin
                        mem_en   = 1'b1;
                        mem_addr = r_pc[AW-1:0];
                        n_state  = lc3is_pkg::ST_DEC;
                    end
                end else if (i_cfg_wr) begin
                    n_pc = i_cfg_pc;
                end
            end
            lc3is_pkg::ST_DEC: begin
                n_ir = mem_rdata;
                if (mem_rdata == lc3is_pkg::HALT_WORD) begin
                    n_halt = 1'b1;
                end
                rf_en   = 1'b1;
                rf_addr = mem_rdata[8:6];
                n_state = lc3is_pkg::ST_RA;
            end
            lc3is_pkg::ST_RA: begin
                n_a   = rf_rd;
                rf_en = 1'b1;
                if (op == lc3is_pkg::OP_ST || op == lc3is_pkg::OP_STI ||
                    op == lc3is_pkg::OP_STR) begin
                    rf_addr = r_ir[11:9];
                end else begin
                    rf_addr = r_ir[2:0];
                end
                unique case (op) inside
                    lc3is_pkg::OP_LD, lc3is_pkg::OP_LDI, lc3is_pkg::OP_STI: begin
                        mem_en   = 1'b1;
                        mem_addr = off9[AW-1:0];
                    end
                    lc3is_pkg::OP_LDR: begin
                        mem_en   = 1'b1;
                        mem_addr = off6_ra[AW-1:0];
                    end
                    default: ;
                endcase
                n_state = lc3is_pkg::ST_RB;
            end
            lc3is_pkg::ST_RB: begin
                instr   = r_ir;
                n_pc    = pc_inc;
                done    = 1'b1;
                n_state = lc3is_pkg::ST_IDLE;
                unique case (op) inside
                    lc3is_pkg::OP_BR: begin
                        if ((r_ir[11:9] & r_cc) != 3'b000) begin
                            n_pc = off9;
                        end
                    end
                    lc3is_pkg::OP_ADD: begin
                        rw = 1'b1;
                        ri = r_ir[11:9];
                        rv = r_a + b_val;
                    end
                    lc3is_pkg::OP_AND: begin
                        rw = 1'b1;
                        ri = r_ir[11:9];
                        rv = r_a & b_val;
                    end
                    lc3is_pkg::OP_NOT: begin
                        rw = 1'b1;
                        ri = r_ir[11:9];
                        rv = ~r_a;
                    end
                    lc3is_pkg::OP_LD, lc3is_pkg::OP_LDR: begin
                        rw = 1'b1;
                        ri = r_ir[11:9];
                        rv = mem_rdata;
                    end
                    lc3is_pkg::OP_LDI: begin
                        // pointer fetched, one more read
                        mem_en   = 1'b1;
                        mem_addr = mem_rdata[AW-1:0];
                        n_pc     = r_pc;
                        instr    = '0;
                        done     = 1'b0;
                        n_state  = lc3is_pkg::ST_IND;
                    end
                    lc3is_pkg::OP_LEA: begin
                        rw = 1'b1;
                        ri = r_ir[11:9];
                        rv = off9;
                    end
                    lc3is_pkg::OP_ST: begin
                        mw = 1'b1;
                        ma = off9;
                        mv = rf_rd;
                    end
                    lc3is_pkg::OP_STI: begin
                        mw = 1'b1;
                        ma = mem_rdata;
                        mv = rf_rd;
                    end
                    lc3is_pkg::OP_STR: begin
                        mw = 1'b1;
                        ma = off6_rb;
                        mv = rf_rd;
                    end
                    lc3is_pkg::OP_JSR: begin
                        rw   = 1'b1;
                        ri   = lc3is_pkg::LINK_REG;
                        rv   = pc_inc;
                        n_pc = r_ir[11] ? (pc_inc + lc3is_pkg::sext11(r_ir)) : r_a;
                    end
                    lc3is_pkg::OP_JMP: begin
                        n_pc = r_a;
                    end
                    default: ;
                endcase
            end
            lc3is_pkg::ST_IND: begin
                instr   = r_ir;
                n_pc    = pc_inc;
                rw      = 1'b1;
                ri      = r_ir[11:9];
                rv      = mem_rdata;
                done    = 1'b1;
                n_state = lc3is_pkg::ST_IDLE;
            end
            default: begin
                n_state = lc3is_pkg::ST_IDLE;
            end
        endcase

        if (rw) begin
            rf_en    = 1'b1;
            rf_we    = 1'b1;
            rf_addr  = ri;
            rf_wdata = rv;
            if (op != lc3is_pkg::OP_LEA) begin
                n_cc = lc3is_pkg::codes_of(rv);
            end
        end
        if (mw) begin
            ma        = lc3is_pkg::mask_addr(ma);
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = ma[AW-1:0];
            mem_wdata = mv;
        end
        // clearing pass after reset owns the memory port
        if (r_clr_act) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lc3is_pkg::ST_IDLE;
            r_pc       <= lc3is_pkg::START_PC_RST;
            r_cc       <= lc3is_pkg::CC_Z;
            r_halt     <= 1'b0;
            r_rf_vld   <= '0;
            r_clr_act  <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cc    <= n_cc;
            r_halt  <= n_halt;
            if (rf_we) begin
                r_rf_vld[rf_addr] <= 1'b1;
            end
            if (r_clr_act) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    r_clr_act <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir <= n_ir;
        r_a  <= n_a;
        if (rf_en && !rf_we) begin
            r_rf_rd_vld <= r_rf_vld[rf_addr];
        end
    end

    assign o_sts.ready    = (r_state == lc3is_pkg::ST_IDLE) && !r_clr_act;
    assign o_sts.clearing = r_clr_act;
    assign o_sts.done     = done;

    assign o_res.pc_after    = n_pc;
    assign o_res.instr_word  = instr;
    assign o_res.cond_after  = n_cc;
    assign o_res.reg_written = rw;
    assign o_res.reg_index   = ri;
    assign o_res.reg_value   = rv;
    assign o_res.mem_written = mw;
    assign o_res.mem_address = ma;
    assign o_res.mem_value   = mv;
    assign o_res.halted      = n_halt;

endmodule
`default_nettype wire
